// ===== rtl/core/dca_pkg.sv =====
// Package for the DMA channel allocator: request and status codes, item,
// result and channel-file command types shared by all allocator modules.
// No dependencies.
package dca_pkg;

	// Default and largest channel count
	localparam int CHANNELS_DEF = 8;
	localparam int CH_MAX       = 8;
	localparam int IDX_W        = 3;
	localparam int CNT_W        = 16;
	localparam int LEN_W        = 16;
	localparam int MAXLEN_W     = 12;

	localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 12'hFFF;
	localparam logic [1:0]          WIDTH_BAD  = 2'd3;

	// Request kinds
	typedef enum logic [2:0] {
		MODE_RESERVE = 3'd0,
		MODE_ALLOC   = 3'd1,
		MODE_CONFIG  = 3'd2,
		MODE_START   = 3'd3,
		MODE_STOP    = 3'd4,
		MODE_RELEASE = 3'd5,
		MODE_EVENT   = 3'd6,
		MODE_QUERY   = 3'd7
	} mode_t;

	// Channel status
	typedef enum logic [2:0] {
		ST_FREE  = 3'd0,
		ST_READY = 3'd1,
		ST_BUSY  = 3'd2,
		ST_DONE  = 3'd3,
		ST_ERROR = 3'd4
	} chan_st_t;

	// Result codes
	typedef enum logic [1:0] {
		RC_OK     = 2'd0,
		RC_PARAM  = 2'd1,
		RC_BUSY   = 2'd2,
		RC_NOFREE = 2'd3
	} rc_t;

	// Counter picked for the shared incrementer
	typedef enum logic [1:0] {
		CNT_OK  = 2'd0,
		CNT_BAD = 2'd1,
		CNT_REL = 2'd2,
		CNT_ANY = 2'd3
	} cnt_sel_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_EXEC = 2'd2,
		S_RESP = 2'd3
	} state_t;

	// One request word, unpacked
	typedef struct packed {
		mode_t             mode;
		logic [3:0]        channel;
		logic              any_channel;
		logic [LEN_W-1:0]  length;
		logic [1:0]        src_width_code;
		logic [1:0]        dst_width_code;
		logic [7:0]        done_mask;
		logic [7:0]        error_mask;
	} item_t;

	// One result word, unpacked
	typedef struct packed {
		rc_t               result_code;
		logic [3:0]        channel_out;
		chan_st_t          status_out;
		logic [CNT_W-1:0]  success_count;
		logic [CNT_W-1:0]  fail_count;
		logic [CNT_W-1:0]  release_count;
		logic [7:0]        done_channels;
		logic [7:0]        error_channels;
	} res_t;

	// Update command into the channel file
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic              set_alloc;
		logic              clr_alloc;
		logic              set_resv;
		logic              wr_status;
		chan_st_t          status;
		logic              wr_cnt;
		cnt_sel_t          cnt_sel;
		logic [CNT_W-1:0]  cnt_val;
		logic              wr_widths;
		logic [1:0]        sw;
		logic [1:0]        dw;
		logic              evt;
		logic [7:0]        dmask;
		logic [7:0]        emask;
	} chan_wr_t;

	// Read data of the addressed channel plus shared state
	typedef struct packed {
		logic              alloc;
		logic              resv;
		chan_st_t          status;
		logic [CNT_W-1:0]  ok_cnt;
		logic [CNT_W-1:0]  bad_cnt;
		logic [CNT_W-1:0]  rel_cnt;
		logic [CNT_W-1:0]  any_fail;
		logic [1:0]        sw;
		logic [1:0]        dw;
	} chan_rd_t;

endpackage

// ===== rtl/core/dca_chan_file.sv =====
// Per-channel state of the DMA channel allocator: flags, status, counters,
// the shared fail counter and the held transfer widths.
// Depends on dca_pkg.
module dca_chan_file #(
	parameter int CHANNELS = dca_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dca_pkg::chan_wr_t             wr,
	input  logic [dca_pkg::IDX_W-1:0]     rd_idx,
	output dca_pkg::chan_rd_t             rd,
	output logic [CHANNELS-1:0]           free_vec
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic                        alloc_q [CHANNELS];
	logic                        resv_q  [CHANNELS];
	dca_pkg::chan_st_t           stat_q  [CHANNELS];
	logic [dca_pkg::CNT_W-1:0]   ok_q    [CHANNELS];
	logic [dca_pkg::CNT_W-1:0]   bad_q   [CHANNELS];
	logic [dca_pkg::CNT_W-1:0]   rel_q   [CHANNELS];
	logic [dca_pkg::CNT_W-1:0]   any_fail_q;
	logic [1:0]                  sw_q;
	logic [1:0]                  dw_q;

	logic [IW-1:0] widx;
	logic [IW-1:0] ridx;

	assign widx = wr.idx[IW-1:0];
	assign ridx = rd_idx[IW-1:0];

	// Free means neither allocated nor reserved
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			free_vec[i] = !alloc_q[i] && !resv_q[i];
		end
	end

	// Read the addressed channel
	always_comb begin
		rd.alloc    = alloc_q[ridx];
		rd.resv     = resv_q[ridx];
		rd.status   = stat_q[ridx];
		rd.ok_cnt   = ok_q[ridx];
		rd.bad_cnt  = bad_q[ridx];
		rd.rel_cnt  = rel_q[ridx];
		rd.any_fail = any_fail_q;
		rd.sw       = sw_q;
		rd.dw       = dw_q;
	end

	// Apply update commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				alloc_q[i] <= 1'b0;
				resv_q[i]  <= 1'b0;
				stat_q[i]  <= dca_pkg::ST_FREE;
				ok_q[i]    <= '0;
				bad_q[i]   <= '0;
				rel_q[i]   <= '0;
			end
			any_fail_q <= '0;
			sw_q       <= '0;
			dw_q       <= '0;
		end else begin
			if (wr.set_alloc) begin
				alloc_q[widx] <= 1'b1;
			end
			if (wr.clr_alloc) begin
				alloc_q[widx] <= 1'b0;
			end
			if (wr.set_resv) begin
				resv_q[widx] <= 1'b1;
			end
			if (wr.wr_status) begin
				stat_q[widx] <= wr.status;
			end
			// Event masks: error wins over done
			if (wr.evt) begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (wr.emask[i]) begin
						stat_q[i] <= dca_pkg::ST_ERROR;
					end else if (wr.dmask[i]) begin
						stat_q[i] <= dca_pkg::ST_DONE;
					end
				end
			end
			if (wr.wr_cnt) begin
				unique case (wr.cnt_sel)
					dca_pkg::CNT_OK:  ok_q[widx]  <= wr.cnt_val;
					dca_pkg::CNT_BAD: bad_q[widx] <= wr.cnt_val;
					dca_pkg::CNT_REL: rel_q[widx] <= wr.cnt_val;
					dca_pkg::CNT_ANY: any_fail_q  <= wr.cnt_val;
					default:          any_fail_q  <= any_fail_q;
				endcase
			end
			if (wr.wr_widths) begin
				sw_q <= wr.sw;
				dw_q <= wr.dw;
			end
		end
	end

endmodule

// ===== rtl/core/dca_ctrl.sv =====
// Sequencer of the DMA channel allocator: free-channel scan, request
// decision, shared counter incrementer and the result register.
// Depends on dca_pkg.
module dca_ctrl #(
	parameter int CHANNELS = dca_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dca_pkg::item_t                  item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dca_pkg::res_t                   res,
	input  logic [dca_pkg::MAXLEN_W-1:0]    max_len,
	input  logic [CHANNELS-1:0]             free_vec,
	input  dca_pkg::chan_rd_t               rd,
	output logic [dca_pkg::IDX_W-1:0]       rd_idx,
	output dca_pkg::chan_wr_t               wr
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);
	localparam logic [8:0] VALID9 = (9'd1 << CHANNELS) - 9'd1;
	localparam logic [7:0] VALID_MASK = VALID9[7:0];

	dca_pkg::state_t  state_q, state_d;
	dca_pkg::item_t   item_q;
	logic [IW-1:0]    ptr_q;
	logic [IW-1:0]    tgt_q;
	logic             found_q;
	dca_pkg::res_t    res_q, res_d;

	logic                       needs_scan;
	logic                       take_any;
	logic                       in_range;
	logic                       bad_width;
	logic                       too_long;
	logic                       misalign;
	logic [2:0]                 len_low;
	logic [2:0]                 dst_mask;
	dca_pkg::cnt_sel_t          cnt_sel;
	logic [dca_pkg::CNT_W-1:0]  cnt_op;
	logic [dca_pkg::CNT_W-1:0]  cnt_inc;

	// Reserve and any-channel allocate/configure search for a free channel
	assign needs_scan = (item.mode == dca_pkg::MODE_RESERVE) ||
		(((item.mode == dca_pkg::MODE_ALLOC) || (item.mode == dca_pkg::MODE_CONFIG)) &&
		item.any_channel);
	assign take_any = ((item_q.mode == dca_pkg::MODE_ALLOC) ||
		(item_q.mode == dca_pkg::MODE_CONFIG)) && item_q.any_channel;
	assign in_range  = {1'b0, item_q.channel} < 5'(CHANNELS);
	assign bad_width = (item_q.src_width_code == dca_pkg::WIDTH_BAD) ||
		(item_q.dst_width_code == dca_pkg::WIDTH_BAD);
	assign too_long  = item_q.length > {4'b0, max_len};

	// Length times source bytes must be a multiple of destination bytes
	assign len_low  = 3'(item_q.length << rd.sw);
	assign dst_mask = 3'((4'd1 << rd.dw) - 4'd1);
	assign misalign = |(len_low & dst_mask);

	assign rd_idx = dca_pkg::IDX_W'(tgt_q);

	// Pick the one counter this request bumps
	always_comb begin
		cnt_sel = dca_pkg::CNT_OK;
		if (take_any) begin
			cnt_sel = found_q ? dca_pkg::CNT_OK : dca_pkg::CNT_ANY;
		end else if ((item_q.mode == dca_pkg::MODE_ALLOC) && rd.alloc) begin
			cnt_sel = dca_pkg::CNT_BAD;
		end else if (item_q.mode == dca_pkg::MODE_RELEASE) begin
			cnt_sel = dca_pkg::CNT_REL;
		end
	end

	// Shared incrementer
	always_comb begin
		unique case (cnt_sel)
			dca_pkg::CNT_OK:  cnt_op = rd.ok_cnt;
			dca_pkg::CNT_BAD: cnt_op = rd.bad_cnt;
			dca_pkg::CNT_REL: cnt_op = rd.rel_cnt;
			dca_pkg::CNT_ANY: cnt_op = rd.any_fail;
			default:          cnt_op = rd.any_fail;
		endcase
	end
	assign cnt_inc = cnt_op + 16'd1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dca_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = needs_scan ? dca_pkg::S_SCAN : dca_pkg::S_EXEC;
				end
			end
			dca_pkg::S_SCAN: begin
				if (free_vec[ptr_q] || (ptr_q == LAST_IDX)) begin
					state_d = dca_pkg::S_EXEC;
				end
			end
			dca_pkg::S_EXEC: state_d = dca_pkg::S_RESP;
			dca_pkg::S_RESP: begin
				if (out_ready) begin
					state_d = dca_pkg::S_IDLE;
				end
			end
			default: state_d = dca_pkg::S_IDLE;
		endcase
	end

	// Outputs: handshakes, channel-file updates and next result
	always_comb begin
		in_ready  = (state_q == dca_pkg::S_IDLE);
		out_valid = (state_q == dca_pkg::S_RESP);
		wr         = '0;
		wr.idx     = dca_pkg::IDX_W'(tgt_q);
		wr.cnt_sel = cnt_sel;
		wr.cnt_val = cnt_inc;
		wr.sw      = item_q.src_width_code;
		wr.dw      = item_q.dst_width_code;
		res_d                = '0;
		res_d.result_code    = dca_pkg::RC_OK;
		res_d.channel_out    = 4'(tgt_q);
		res_d.status_out     = rd.status;
		res_d.success_count  = rd.ok_cnt;
		res_d.fail_count     = rd.bad_cnt;
		res_d.release_count  = rd.rel_cnt;
		if (state_q == dca_pkg::S_EXEC) begin
			if (item_q.mode == dca_pkg::MODE_EVENT) begin
				wr.evt   = 1'b1;
				wr.dmask = item_q.done_mask & VALID_MASK;
				wr.emask = item_q.error_mask & VALID_MASK;
				res_d                = '0;
				res_d.done_channels  = item_q.done_mask & VALID_MASK;
				res_d.error_channels = item_q.error_mask & VALID_MASK;
			end else if (item_q.mode == dca_pkg::MODE_RESERVE) begin
				if (!found_q) begin
					res_d             = '0;
					res_d.result_code = dca_pkg::RC_NOFREE;
					res_d.fail_count  = rd.any_fail;
				end else begin
					wr.set_resv = 1'b1;
				end
			end else if (take_any) begin
				if (!found_q) begin
					wr.wr_cnt         = 1'b1;
					res_d             = '0;
					res_d.result_code = (item_q.mode == dca_pkg::MODE_ALLOC) ?
						dca_pkg::RC_NOFREE : dca_pkg::RC_BUSY;
					res_d.fail_count  = cnt_inc;
				end else begin
					// Take the channel, then configure it if asked
					wr.set_alloc        = 1'b1;
					wr.wr_status        = 1'b1;
					wr.status           = dca_pkg::ST_READY;
					wr.wr_cnt           = 1'b1;
					res_d.status_out    = dca_pkg::ST_READY;
					res_d.success_count = cnt_inc;
					if (item_q.mode == dca_pkg::MODE_CONFIG) begin
						if (bad_width) begin
							res_d.result_code = dca_pkg::RC_PARAM;
						end else begin
							wr.wr_widths = 1'b1;
						end
					end
				end
			end else if (!in_range) begin
				res_d             = '0;
				res_d.result_code = dca_pkg::RC_PARAM;
				res_d.channel_out = item_q.channel;
			end else begin
				unique case (item_q.mode)
					dca_pkg::MODE_ALLOC: begin
						wr.wr_cnt = 1'b1;
						if (rd.alloc) begin
							res_d.result_code = dca_pkg::RC_BUSY;
							res_d.fail_count  = cnt_inc;
						end else begin
							wr.set_alloc        = 1'b1;
							wr.wr_status        = 1'b1;
							wr.status           = dca_pkg::ST_READY;
							res_d.status_out    = dca_pkg::ST_READY;
							res_d.success_count = cnt_inc;
						end
					end
					dca_pkg::MODE_CONFIG: begin
						if (!rd.alloc && !rd.resv) begin
							res_d.result_code = dca_pkg::RC_BUSY;
						end else if (bad_width) begin
							res_d.result_code = dca_pkg::RC_PARAM;
						end else begin
							wr.wr_widths     = 1'b1;
							wr.wr_status     = 1'b1;
							wr.status        = dca_pkg::ST_READY;
							res_d.status_out = dca_pkg::ST_READY;
						end
					end
					dca_pkg::MODE_START: begin
						if (too_long) begin
							res_d.result_code = dca_pkg::RC_PARAM;
						end else begin
							wr.wr_status     = 1'b1;
							wr.status        = dca_pkg::ST_BUSY;
							res_d.status_out = dca_pkg::ST_BUSY;
							if (misalign) begin
								res_d.result_code = dca_pkg::RC_PARAM;
							end
						end
					end
					dca_pkg::MODE_STOP: begin
						wr.wr_status     = 1'b1;
						wr.status        = dca_pkg::ST_DONE;
						res_d.status_out = dca_pkg::ST_DONE;
					end
					dca_pkg::MODE_RELEASE: begin
						wr.wr_status        = 1'b1;
						wr.status           = dca_pkg::ST_FREE;
						wr.clr_alloc        = 1'b1;
						wr.wr_cnt           = 1'b1;
						res_d.status_out    = dca_pkg::ST_FREE;
						res_d.release_count = cnt_inc;
					end
					default: begin
						res_d.result_code = dca_pkg::RC_OK;
					end
				endcase
			end
		end
	end

	assign res = res_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dca_pkg::S_IDLE;
			ptr_q   <= '0;
			tgt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				dca_pkg::S_IDLE: begin
					if (in_valid) begin
						ptr_q   <= '0;
						found_q <= 1'b0;
						tgt_q   <= item.channel[IW-1:0];
					end
				end
				dca_pkg::S_SCAN: begin
					// Advance one channel a cycle until a free one turns up
					if (free_vec[ptr_q]) begin
						found_q <= 1'b1;
						tgt_q   <= ptr_q;
					end else if (ptr_q != LAST_IDX) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

	// Hold the request word and the result word
	always_ff @(posedge clk) begin
		if (in_valid && (state_q == dca_pkg::S_IDLE)) begin
			item_q <= item;
		end
		if (state_q == dca_pkg::S_EXEC) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== rtl/core/dma_channel_allocator.sv =====
// DMA channel allocator top level: stream ports, length limit register,
// channel file and request sequencer.
// Depends on dca_pkg, dca_chan_file and dca_ctrl.

// One request word is taken when s_tready is high, and s_tready is high only
// while no earlier request is in flight. A request that names a channel, or
// needs no search, goes through the execute state and raises m_tvalid once its
// result word is registered. Reserve, and allocate or configure with any_channel
// set, first scan the channels one per cycle. The scan stops at the first free
// channel, or after the last channel when none is free. The result word then
// waits in an output register until m_tready. s_tready is high again in the
// cycle that follows that handshake. Write max_block_length through
// cfg_wen/cfg_wdata only while no request is in flight.
module dma_channel_allocator #(
	parameter int CHANNELS = dca_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// channel[3:0], any_channel[4], length[20:5], src_width_code[22:21],
	// dst_width_code[24:23], done_mask[32:25], error_mask[40:33], zero pad
	input  logic [47:0] s_tdata,
	// mode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_code[1:0], channel_out[5:2], status_out[8:6],
	// success_count[24:9], fail_count[40:25], release_count[56:41],
	// done_channels[64:57], error_channels[72:65], zero pad
	output logic [79:0] m_tdata,
	input  logic        cfg_wen,
	input  logic [11:0] cfg_wdata
);

	logic [dca_pkg::MAXLEN_W-1:0] max_len_q;
	dca_pkg::item_t               item;
	dca_pkg::res_t                res;
	dca_pkg::chan_wr_t            wr;
	dca_pkg::chan_rd_t            rd;
	logic [dca_pkg::IDX_W-1:0]    rd_idx;
	logic [CHANNELS-1:0]          free_vec;

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= dca_pkg::MAXLEN_RST;
		end else if (cfg_wen) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Unpack the request word
	always_comb begin
		item.mode           = dca_pkg::mode_t'(s_tuser);
		item.channel        = s_tdata[3:0];
		item.any_channel    = s_tdata[4];
		item.length         = s_tdata[20:5];
		item.src_width_code = s_tdata[22:21];
		item.dst_width_code = s_tdata[24:23];
		item.done_mask      = s_tdata[32:25];
		item.error_mask     = s_tdata[40:33];
	end

	// Pack the result word
	assign m_tdata = {7'd0,
		res.error_channels, res.done_channels,
		res.release_count, res.fail_count, res.success_count,
		res.status_out, res.channel_out, res.result_code};

	dca_chan_file #(
		.CHANNELS (CHANNELS)
	) u_chan_file (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_idx   (rd_idx),
		.rd       (rd),
		.free_vec (free_vec)
	);

	dca_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res),
		.max_len   (max_len_q),
		.free_vec  (free_vec),
		.rd        (rd),
		.rd_idx    (rd_idx),
		.wr        (wr)
	);

endmodule
